### hw/rtl/smss_pkg.sv
// ----------------------------------------------------------------------------
// smss_pkg
// Shared types and constants for the sensor matrix scan sequencer.
// ----------------------------------------------------------------------------
package smss_pkg;

  localparam int unsigned MAX_SIDE  = 16;
  localparam int unsigned CNT_W     = $clog2(MAX_SIDE);
  localparam int unsigned SIDE_W    = CNT_W + 1;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 5;

  localparam logic [7:0] COL_BASE = 8'd64;
  localparam logic [7:0] ROW_BASE = 8'd32;
  localparam logic [7:0] MUX_IDLE = 8'd0;

  localparam logic [1:0] ONE_WRITE = 2'd1;
  localparam logic [1:0] TWO_WRITES = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SIDE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] step;
    logic [CNT_W-1:0] col;
  } scan_state_t;

  typedef struct packed {
    logic [7:0] frame_index;
    logic [7:0] stored_sample;
    logic [7:0] mux_first;
    logic [7:0] mux_second;
    logic [1:0] mux_write_count;
    logic       frame_done;
  } result_t;

endpackage

### hw/rtl/smss_ifs.sv
// ----------------------------------------------------------------------------
// smss channel interfaces
// Valid/ready channels for samples in and tagged results out.
// ----------------------------------------------------------------------------
interface smss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface smss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_index;
  logic [7:0] stored_sample;
  logic [7:0] mux_first;
  logic [7:0] mux_second;
  logic [1:0] mux_write_count;
  logic       frame_done;

  modport source (
    output valid, output frame_index, output stored_sample, output mux_first,
    output mux_second, output mux_write_count, output frame_done, input ready
  );
  modport sink (
    input valid, input frame_index, input stored_sample, input mux_first,
    input mux_second, input mux_write_count, input frame_done, output ready
  );
endinterface

### hw/rtl/sensor_matrix_scan_sequencer.sv
// ----------------------------------------------------------------------------
// sensor_matrix_scan_sequencer
// Tags converted matrix samples with their frame position and produces the
// next row/column multiplexer words.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one converted sample per request; out_chan returns one
//   result per sample: frame index, the sample, one or two mux words and a
//   frame-done flag. A sample passes an input register and a result
//   register, so its result is offered once it has moved from the input
//   register into the result register. Throughput is one sample per cycle
//   while the receiver takes results; the limit is the single counter
//   update per sample, which runs between those two registers.
//   cfg_we/cfg_index/cfg_wdata write side_count (index 0) and order_mode
//   (index 1); writes to other indexes are ignored. Change them only while
//   no sample is in flight.
//   Reset clears the counters to the first crossing, sets side 16 and
//   linear order, and empties both registers.
//   When the receiver stalls the result register holds, the input register
//   still takes one more sample, and then in_chan.ready drops.
// ----------------------------------------------------------------------------
module sensor_matrix_scan_sequencer
  import smss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  smss_in_if.sink              in_chan,
  smss_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  logic                 s1_valid_r, s1_valid_nxt;
  logic [7:0]           s1_sample_r;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_r;
  scan_state_t          state_r, state_nxt;
  logic [CFG_DAT_W-1:0] side_r;
  logic                 order_r;
  result_t              step_result;
  scan_state_t          step_state;
  logic                 in_fire;
  logic                 adv;

  smss_step u_step (
    .side_count (side_r),
    .order_mode (order_r),
    .state_cur  (state_r),
    .sample     (s1_sample_r),
    .result     (step_result),
    .state_nxt  (step_state)
  );

  assign adv = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || adv;
  assign in_fire = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt = in_fire ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
    state_nxt = adv ? step_state : state_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      state_r <= '0;
      side_r <= CFG_DAT_W'(MAX_SIDE);
      order_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SIDE_COUNT: side_r <= cfg_wdata;
          REG_ORDER_MODE: order_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_chan.sample;
    end
    if (adv) begin
      out_r <= step_result;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.frame_index = out_r.frame_index;
  assign out_chan.stored_sample = out_r.stored_sample;
  assign out_chan.mux_first = out_r.mux_first;
  assign out_chan.mux_second = out_r.mux_second;
  assign out_chan.mux_write_count = out_r.mux_write_count;
  assign out_chan.frame_done = out_r.frame_done;

  // a frame end returns the scan to the first crossing
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    adv && step_result.frame_done |=> state_r == '0)
    else $error("counters not cleared after frame end");

  // a row end restarts step and column
  a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
    adv && step_result.mux_write_count == TWO_WRITES |=>
      state_r.step == '0 && state_r.col == '0)
    else $error("step or column not cleared at row end");

  // a held sample is never dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_sample_r))
    else $error("pending sample lost");

  // an empty result register never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_chan.ready)
    else $error("input stalled with empty result register");

  // counters only move when a result is produced
  a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(state_r))
    else $error("counters changed without a sample");

endmodule

### hw/rtl/smss_step.sv
// ----------------------------------------------------------------------------
// smss_step
// One scan step: tags a sample and advances the row/step/column counters.
// ----------------------------------------------------------------------------
module smss_step
  import smss_pkg::*;
(
  input  logic [CFG_DAT_W-1:0] side_count,
  input  logic                 order_mode,
  input  scan_state_t          state_cur,
  input  logic [7:0]           sample,
  output result_t              result,
  output scan_state_t          state_nxt
);

  logic [SIDE_W-1:0] side_clamp;
  logic [SIDE_W-1:0] side;
  logic [CNT_W-1:0]  half_m1;
  logic [CNT_W-1:0]  side_m1;
  logic [SIDE_W-1:0] step_inc;
  logic [SIDE_W-1:0] row_inc;
  logic [CNT_W+SIDE_W-1:0] idx_full;
  logic [CNT_W-1:0]  col_nxt;

  always_comb begin
    // clamp, round down to even, floor at two
    side_clamp = (side_count > CFG_DAT_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                      : SIDE_W'(side_count);
    side = {side_clamp[SIDE_W-1:1], 1'b0};
    if (side < SIDE_W'(2)) begin
      side = SIDE_W'(2);
    end
    half_m1 = CNT_W'((side >> 1) - SIDE_W'(1));
    side_m1 = CNT_W'(side - SIDE_W'(1));
    step_inc = SIDE_W'(state_cur.step) + SIDE_W'(1);
    row_inc = SIDE_W'(state_cur.row) + SIDE_W'(1);
    idx_full = state_cur.row * side + (CNT_W+SIDE_W)'(state_cur.step);

    if (!order_mode) begin
      col_nxt = state_cur.col + CNT_W'(1);
    end else begin
      priority if (state_cur.col > half_m1) begin
        col_nxt = state_cur.col - CNT_W'(1);
      end else if (state_cur.col == half_m1) begin
        col_nxt = side_m1;
      end else begin
        col_nxt = state_cur.col + CNT_W'(1);
      end
    end

    result.frame_index = idx_full[7:0];
    result.stored_sample = sample;
    state_nxt = '0;

    if (step_inc >= side) begin
      if (row_inc >= side) begin
        result.mux_first = MUX_IDLE;
        result.mux_second = MUX_IDLE;
        result.mux_write_count = ONE_WRITE;
        result.frame_done = 1'b1;
      end else begin
        // row end: column word back to base, then the new row word
        state_nxt.row = row_inc[CNT_W-1:0];
        result.mux_first = COL_BASE;
        result.mux_second = ROW_BASE + 8'(row_inc[CNT_W-1:0]);
        result.mux_write_count = TWO_WRITES;
        result.frame_done = 1'b0;
      end
    end else begin
      state_nxt.row = state_cur.row;
      state_nxt.step = step_inc[CNT_W-1:0];
      state_nxt.col = col_nxt;
      result.mux_first = COL_BASE + 8'(col_nxt);
      result.mux_second = MUX_IDLE;
      result.mux_write_count = ONE_WRITE;
      result.frame_done = 1'b0;
    end
  end

endmodule
